>>> rtl/core/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants of the touch tap and drag detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ttd_pkg;

	// Item function codes.
	localparam logic FUNC_TOUCH = 1'b0;
	localparam logic FUNC_POLL  = 1'b1;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TOUCHABLE = 2'd0;
	localparam cfg_idx_t REG_DRAG_X    = 2'd1;
	localparam cfg_idx_t REG_DRAG_Y    = 2'd2;
	localparam cfg_idx_t REG_THRESHOLD = 2'd3;

	localparam int CFG_DATA_W = 8;
	localparam int THR_SQ_W   = 2 * CFG_DATA_W;

	// Reset values of the registers.
	localparam logic                  TOUCHABLE_RST = 1'b1;
	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 8'd5;
	localparam logic [THR_SQ_W-1:0]   THR_SQ_RST    = 16'd25;

	typedef struct packed {
		logic                touchable;
		logic                drag_x;
		logic                drag_y;
		logic [THR_SQ_W-1:0] thr_sq;
	} cfg_t;

	// Distance check result for the current event.
	typedef struct packed {
		logic beyond;
		logic x_dom;
		logic y_dom;
	} dist_t;

endpackage

`default_nettype wire

>>> rtl/core/touch_tap_drag_detector.sv
// The result of an accepted transaction waits in the input register and is
// loaded into the result register once that register is free or emptying.
// Throughput: one transaction per cycle unless the output stalls; touch
// state updates as each event moves from input to result register.
// Reset: no touch owned, tap flag clear, touchable set, both drag axes off,
// drag threshold 5.
// ----------------------------------------------------------------------------
// touch_tap_drag_detector
// Tracks one touch owner of a screen element and reports press, hover,
// drag and tap status for every event or poll.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_tap_drag_detector #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire ttd_pkg::cfg_idx_t              cfg_index,
	input  wire logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [2:0]                     touch_index,
	input  wire logic signed [COORD_BITS-1:0]   pos_x,
	input  wire logic signed [COORD_BITS-1:0]   pos_y,
	input  wire logic                           pressed,
	input  wire logic                           moved,
	input  wire logic                           cancel,
	input  wire logic                           inside_req,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                accepted,
	output logic                                owned,
	output logic                                hovering,
	output logic                                dragging,
	output logic                                press_started,
	output logic                                tap_released
);

	ttd_pkg::cfg_t  cfg;
	ttd_pkg::dist_t span;

	// Input register.
	logic                         valid_s1;
	logic                         func_s1;
	logic [2:0]                   index_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic                         pressed_s1;
	logic                         moved_s1;
	logic                         cancel_s1;
	logic                         inside_s1;

	// Touch state.
	logic                         active_q;
	logic [2:0]                   owner_q;
	logic                         hover_q;
	logic                         drag_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;
	logic                         tap_q;

	logic take_in;
	logic go;

	logic active_d;
	logic [2:0] owner_d;
	logic hover_d;
	logic drag_d;
	logic tap_d;
	logic start_load;
	logic acc_d;
	logic started_d;
	logic tap_out_d;
	logic abort;
	logic drag_ok;

	ttd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ttd_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.pos_x   (x_s1),
		.pos_y   (y_s1),
		.start_x (start_x_q),
		.start_y (start_y_q),
		.thr_sq  (cfg.thr_sq),
		.span    (span)
	);

	// The event in the input register is processed when the result register
	// is free or is being emptied in the same cycle.
	assign go       = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1    <= func;
			index_s1   <= touch_index;
			x_s1       <= pos_x;
			y_s1       <= pos_y;
			pressed_s1 <= pressed;
			moved_s1   <= moved;
			cancel_s1  <= cancel;
			inside_s1  <= inside_req;
		end
	end

	assign abort   = cancel_s1 || !cfg.touchable;
	assign drag_ok = span.beyond && ((cfg.drag_x && cfg.drag_y) ||
		(cfg.drag_x && span.x_dom) || (cfg.drag_y && span.y_dom));

	always_comb begin
		active_d   = active_q;
		owner_d    = owner_q;
		hover_d    = hover_q;
		drag_d     = drag_q;
		tap_d      = tap_q;
		start_load = 1'b0;
		acc_d      = 1'b0;
		started_d  = 1'b0;
		tap_out_d  = 1'b0;
		if (func_s1 == ttd_pkg::FUNC_POLL) begin
			tap_out_d = tap_q;
			tap_d     = 1'b0;
		end else if (!active_q) begin
			if (pressed_s1 && !moved_s1 && !abort && inside_s1) begin
				owner_d    = index_s1;
				active_d   = 1'b1;
				hover_d    = 1'b1;
				drag_d     = 1'b0;
				start_load = 1'b1;
				acc_d      = 1'b1;
				started_d  = 1'b1;
			end
		end else if (owner_q == index_s1) begin
			if (abort) begin
				active_d = 1'b0;
				hover_d  = 1'b0;
			end else if (pressed_s1) begin
				hover_d = inside_s1;
				if (moved_s1 && !drag_q && drag_ok) begin
					drag_d = 1'b1;
				end
				acc_d = 1'b1;
			end else begin
				// Release by the owner; a release inside counts as a tap.
				active_d = 1'b0;
				hover_d  = 1'b0;
				if (inside_s1) begin
					tap_d = 1'b1;
				end
				acc_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			owner_q   <= 3'd0;
			hover_q   <= 1'b0;
			drag_q    <= 1'b0;
			tap_q     <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (go) begin
			active_q <= active_d;
			owner_q  <= owner_d;
			hover_q  <= hover_d;
			drag_q   <= drag_d;
			tap_q    <= tap_d;
			if (start_load) begin
				start_x_q <= x_s1;
				start_y_q <= y_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			accepted      <= acc_d;
			owned         <= active_d;
			hovering      <= hover_d;
			dragging      <= drag_d;
			press_started <= started_d;
			tap_released  <= tap_out_d;
		end
	end

	a_start_is_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_started |-> accepted && owned && hovering && !dragging)
		else $error("press start reported without a claimed touch");

	a_poll_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tap_released |-> !accepted && !press_started)
		else $error("poll result carries touch event flags");

	a_hover_needs_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !hover_q)
		else $error("hover set with no active touch");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled while the pipeline has room");

	a_tap_from_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tap_q) |-> $past(active_q) && !active_q)
		else $error("tap flag set without an owner release");

endmodule

`default_nettype wire

>>> rtl/core/ttd_cfg.sv
// ----------------------------------------------------------------------------
// ttd_cfg
// Configuration registers; keeps the squared drag threshold ready for use.
// ----------------------------------------------------------------------------
`default_nettype none

module ttd_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire ttd_pkg::cfg_idx_t             cfg_index,
	input  wire logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data,
	output ttd_pkg::cfg_t                      cfg
);

	logic                           touchable_q;
	logic                           drag_x_q;
	logic                           drag_y_q;
	logic [ttd_pkg::THR_SQ_W-1:0]   thr_sq_q;
	logic [ttd_pkg::THR_SQ_W-1:0]   thr_sq_next;

	// The threshold is squared once at write time rather than per event.
	assign thr_sq_next = ttd_pkg::THR_SQ_W'(cfg_data) * ttd_pkg::THR_SQ_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touchable_q <= ttd_pkg::TOUCHABLE_RST;
			drag_x_q    <= 1'b0;
			drag_y_q    <= 1'b0;
			thr_sq_q    <= ttd_pkg::THR_SQ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttd_pkg::REG_TOUCHABLE: touchable_q <= cfg_data[0];
				ttd_pkg::REG_DRAG_X:    drag_x_q    <= cfg_data[0];
				ttd_pkg::REG_DRAG_Y:    drag_y_q    <= cfg_data[0];
				ttd_pkg::REG_THRESHOLD: thr_sq_q    <= thr_sq_next;
				default: ;
			endcase
		end
	end

	assign cfg = {touchable_q, drag_x_q, drag_y_q, thr_sq_q};

endmodule

`default_nettype wire

>>> rtl/core/ttd_dist.sv
// ----------------------------------------------------------------------------
// ttd_dist
// Squared distance from the start point against the threshold, plus the
// dominant axis of the motion.
// ----------------------------------------------------------------------------
`default_nettype none

module ttd_dist #(
	parameter int COORD_BITS = 16
) (
	input  wire logic signed [COORD_BITS-1:0]    pos_x,
	input  wire logic signed [COORD_BITS-1:0]    pos_y,
	input  wire logic signed [COORD_BITS-1:0]    start_x,
	input  wire logic signed [COORD_BITS-1:0]    start_y,
	input  wire logic [ttd_pkg::THR_SQ_W-1:0]    thr_sq,
	output ttd_pkg::dist_t                       span
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 1;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic        [DIFF_W-1:0] ax;
	logic        [DIFF_W-1:0] ay;
	logic        [SQ_W-1:0]   sx;
	logic        [SQ_W-1:0]   sy;
	logic        [SUM_W-1:0]  sum;

	assign dx = DIFF_W'(pos_x) - DIFF_W'(start_x);
	assign dy = DIFF_W'(pos_y) - DIFF_W'(start_y);
	assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	// The sum is kept at full width, so it never wraps.
	assign sx  = SQ_W'(ax) * SQ_W'(ax);
	assign sy  = SQ_W'(ay) * SQ_W'(ay);
	assign sum = SUM_W'(sx) + SUM_W'(sy);

	assign span = {sum > SUM_W'(thr_sq), ax > ay, ay > ax};

endmodule

`default_nettype wire

>>> tb/tb_touch_tap_drag_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_tap_drag_detector
// Drives touch events and polls into the tap and drag detector, predicts the
// ownership, hover, drag and tap status of every transaction, and compares
// each result with the prediction. It covers directed corner cases, then
// random gestures under several register settings, most of them with random
// idling on both sides.
// ----------------------------------------------------------------------------

module tb_touch_tap_drag_detector;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 9;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we      = 1'b0;
	ttd_pkg::cfg_idx_t              cfg_index   = ttd_pkg::REG_TOUCHABLE;
	logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic                           func        = ttd_pkg::FUNC_TOUCH;
	logic [2:0]                     touch_index = '0;
	logic signed [15:0]             pos_x       = '0;
	logic signed [15:0]             pos_y       = '0;
	logic                           pressed     = 1'b0;
	logic                           moved       = 1'b0;
	logic                           cancel      = 1'b0;
	logic                           inside_req  = 1'b0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic                           accepted;
	logic                           owned;
	logic                           hovering;
	logic                           dragging;
	logic                           press_started;
	logic                           tap_released;

	typedef struct {
		logic               func;
		logic [2:0]         idx;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               pressed;
		logic               moved;
		logic               cancel;
		logic               in_area;
	} touch_event_t;

	typedef struct {
		logic accepted;
		logic owned;
		logic hovering;
		logic dragging;
		logic started;
		logic tap;
	} touch_status_t;

	class touch_status_board;
		bit                 touchable;
		bit                 drag_x_en;
		bit                 drag_y_en;
		bit [7:0]           threshold;
		bit                 active;
		bit [2:0]           owner;
		bit                 hover;
		bit                 drag;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		bit                 tap_flag;
		touch_status_t      expected_status_q[$];
		int                 errors;

		function new();
			touchable = ttd_pkg::TOUCHABLE_RST;
			drag_x_en = 1'b0;
			drag_y_en = 1'b0;
			threshold = ttd_pkg::THRESHOLD_RST;
			active    = 1'b0;
			owner     = '0;
			hover     = 1'b0;
			drag      = 1'b0;
			start_x   = '0;
			start_y   = '0;
			tap_flag  = 1'b0;
			errors    = 0;
		endfunction

		function void write_reg(ttd_pkg::cfg_idx_t idx,
				logic [ttd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ttd_pkg::REG_TOUCHABLE: touchable = data[0];
				ttd_pkg::REG_DRAG_X:    drag_x_en = data[0];
				ttd_pkg::REG_DRAG_Y:    drag_y_en = data[0];
				ttd_pkg::REG_THRESHOLD: threshold = data;
				default: ;
			endcase
		endfunction

		// Updates the touch state for one accepted transaction and queues the
		// status it must produce. Returns 1 when the item was accepted or was a poll.
		function bit note_event(touch_event_t ev);
			touch_status_t      st;
			bit                 aborted;
			longint             dx;
			longint             dy;
			longint unsigned    ax;
			longint unsigned    ay;
			longint unsigned    thr_sq;
			st = '{default: 1'b0};
			aborted = ev.cancel || !touchable;
			if (ev.func == ttd_pkg::FUNC_POLL) begin
				st.tap = tap_flag;
				tap_flag = 1'b0;
			end else if (!active) begin
				if (ev.pressed && !ev.moved && !aborted && ev.in_area) begin
					owner = ev.idx;
					active = 1'b1;
					hover = 1'b1;
					drag = 1'b0;
					start_x = ev.x;
					start_y = ev.y;
					st.accepted = 1'b1;
					st.started = 1'b1;
				end
			end else if (owner == ev.idx) begin
				if (aborted) begin
					active = 1'b0;
					hover = 1'b0;
				end else if (ev.pressed) begin
					hover = ev.in_area;
					if (ev.moved && !drag) begin
						dx = longint'(ev.x) - longint'(start_x);
						dy = longint'(ev.y) - longint'(start_y);
						ax = (dx < 0) ? -dx : dx;
						ay = (dy < 0) ? -dy : dy;
						thr_sq = longint'(threshold) * longint'(threshold);
						// With 16-bit coordinates the sum of squares cannot wrap.
						if (ax * ax + ay * ay > thr_sq) begin
							if (drag_x_en && drag_y_en)
								drag = 1'b1;
							else if (drag_x_en && ax > ay)
								drag = 1'b1;
							else if (drag_y_en && ay > ax)
								drag = 1'b1;
						end
					end
					st.accepted = 1'b1;
				end else begin
					active = 1'b0;
					hover = 1'b0;
					if (ev.in_area)
						tap_flag = 1'b1;
					st.accepted = 1'b1;
				end
			end
			st.owned = active;
			st.hovering = hover;
			st.dragging = drag;
			expected_status_q.push_back(st);
			return st.accepted || (ev.func == ttd_pkg::FUNC_POLL);
		endfunction

		function void check_bit(string field, logic want, logic got);
			if (want !== got) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_status(touch_status_t got);
			touch_status_t want;
			if (expected_status_q.size() == 0) begin
				$error("result transaction with no pending event");
				errors++;
				return;
			end
			want = expected_status_q.pop_front();
			check_bit("accepted", want.accepted, got.accepted);
			check_bit("owned", want.owned, got.owned);
			check_bit("hovering", want.hovering, got.hovering);
			check_bit("dragging", want.dragging, got.dragging);
			check_bit("press_started", want.started, got.started);
			check_bit("tap_released", want.tap, got.tap);
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction
	endclass

	touch_status_board sb = new();

	int send_idle_pct = 8;
	int recv_idle_pct = 48;
	int hold_req      = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	int sent_items    = 0;

	touch_tap_drag_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.touch_index   (touch_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pressed       (pressed),
		.moved         (moved),
		.cancel        (cancel),
		.inside_req    (inside_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.owned         (owned),
		.hovering      (hovering),
		.dragging      (dragging),
		.press_started (press_started),
		.tap_released  (tap_released)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic touch_event_t ev_touch(logic [2:0] idx, logic signed [15:0] x,
			logic signed [15:0] y, bit prs, bit mov, bit cnc, bit in_area);
		touch_event_t ev;
		ev.func = ttd_pkg::FUNC_TOUCH;
		ev.idx = idx;
		ev.x = x;
		ev.y = y;
		ev.pressed = prs;
		ev.moved = mov;
		ev.cancel = cnc;
		ev.in_area = in_area;
		return ev;
	endfunction

	function automatic touch_event_t ev_noise();
		touch_event_t ev;
		ev = ev_touch(3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom));
		ev.func = 1'($urandom);
		return ev;
	endfunction

	function automatic touch_event_t ev_poll();
		touch_event_t ev;
		ev = ev_noise();
		ev.func = ttd_pkg::FUNC_POLL;
		return ev;
	endfunction

	task automatic send_event(touch_event_t ev);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= ev.func;
		touch_index <= ev.idx;
		pos_x <= ev.x;
		pos_y <= ev.y;
		pressed <= ev.pressed;
		moved <= ev.moved;
		cancel <= ev.cancel;
		inside_req <= ev.in_area;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		void'(sb.note_event(ev));
		sent_items++;
	endtask

	// Every item yields a result, so an empty queue means the pipeline is idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(bit tch, bit dx_en, bit dy_en, logic [7:0] thr);
		cfg_we <= 1'b1;
		cfg_index <= ttd_pkg::REG_TOUCHABLE;
		cfg_data <= ttd_pkg::CFG_DATA_W'(tch);
		@(posedge clk);
		sb.write_reg(ttd_pkg::REG_TOUCHABLE, ttd_pkg::CFG_DATA_W'(tch));
		cfg_index <= ttd_pkg::REG_DRAG_X;
		cfg_data <= ttd_pkg::CFG_DATA_W'(dx_en);
		@(posedge clk);
		sb.write_reg(ttd_pkg::REG_DRAG_X, ttd_pkg::CFG_DATA_W'(dx_en));
		cfg_index <= ttd_pkg::REG_DRAG_Y;
		cfg_data <= ttd_pkg::CFG_DATA_W'(dy_en);
		@(posedge clk);
		sb.write_reg(ttd_pkg::REG_DRAG_Y, ttd_pkg::CFG_DATA_W'(dy_en));
		cfg_index <= ttd_pkg::REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		sb.write_reg(ttd_pkg::REG_THRESHOLD, thr);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A press inside, a run of moves around the threshold mixed with foreign
	// events, polls and noise, and then a release, a cancel or nothing.
	task automatic run_gesture();
		touch_event_t       ev;
		logic [2:0]         idx;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		int                 reach;
		int                 dx;
		int                 dy;
		int                 pick;
		idx = 3'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			sx = 16'($urandom);
			sy = 16'($urandom);
		end else begin
			sx = 16'(int'($urandom_range(0, 2000)) - 1000);
			sy = 16'(int'($urandom_range(0, 2000)) - 1000);
		end
		send_event(ev_touch(idx, sx, sy, 1'b1, 1'b0, 1'b0, 1'b1));
		repeat ($urandom_range(1, 8)) begin
			pick = $urandom_range(0, 99);
			reach = 2 * int'(sb.threshold) + 2;
			if (pick < 70) begin
				dx = $urandom_range(0, 2 * reach) - reach;
				dy = $urandom_range(0, 2 * reach) - reach;
				if ($urandom_range(0, 6) == 0)
					dy = $urandom_range(0, 1) ? dx : -dx;
				if ($urandom_range(0, 19) == 0)
					ev = ev_touch(idx, 16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b0,
						1'($urandom));
				else
					ev = ev_touch(idx, 16'(sx + dx), 16'(sy + dy), 1'b1,
						$urandom_range(0, 5) != 0, 1'b0, $urandom_range(0, 3) != 0);
			end else if (pick < 80) begin
				ev = ev_noise();
				ev.func = ttd_pkg::FUNC_TOUCH;
				ev.idx = idx + 3'($urandom_range(1, 7));
			end else if (pick < 90) begin
				ev = ev_poll();
			end else begin
				ev = ev_noise();
			end
			send_event(ev);
		end
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_event(ev_touch(idx, 16'(sx + 16'sd1), 16'(sy - 16'sd1), 1'b0,
				1'($urandom), 1'b0, 1'b1));
		else if (pick < 70)
			send_event(ev_touch(idx, sx, sy, 1'b0, 1'($urandom), 1'b0, 1'b0));
		else if (pick < 85)
			send_event(ev_touch(idx, 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom), 1'b1, 1'($urandom)));
		if ($urandom_range(0, 2) == 0)
			send_event(ev_poll());
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		touch_status_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.accepted = accepted;
			got.owned = owned;
			got.hovering = hovering;
			got.dragging = dragging;
			got.started = press_started;
			got.tap = tap_released;
			sb.check_status(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		bit       ph_touchable [NUM_PHASES];
		bit       ph_drag_x    [NUM_PHASES];
		bit       ph_drag_y    [NUM_PHASES];
		bit [7:0] ph_threshold [NUM_PHASES];
		int       ph_budget    [NUM_PHASES];
		int       phase_start;

		arst_n <= 1'b0;
		ph_touchable = '{1, 1, 1, 0, 1, 1, 1, 1, 1};
		ph_drag_x    = '{1, 1, 0, 1, 1, 0, 1, 0, 1};
		ph_drag_y    = '{1, 0, 1, 1, 1, 1, 0, 0, 1};
		ph_threshold = '{0, 255, 17, 5, 3, 0, 40, 255, 255};
		ph_budget    = '{165, 165, 165, 30, 165, 165, 165, 165, 165};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: touchable, no drag axis, threshold 5.
		send_event(ev_poll());
		send_event(ev_touch(3'd3, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(ev_touch(3'd3, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0));
		send_event(ev_touch(3'd3, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b1));
		send_event(ev_touch(3'd3, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_event(ev_touch(3'd3, -16'sd32768, 16'sd32767, 1'b1, 1'b0, 1'b0, 1'b1));
		send_event(ev_touch(3'd5, 16'sd1, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b1));
		// Full-scale travel in both axes, but no axis is enabled.
		send_event(ev_touch(3'd3, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(ev_touch(3'd3, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b1));
		send_event(ev_poll());
		send_event(ev_poll());
		send_event(ev_touch(3'd7, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1));
		send_event(ev_touch(3'd7, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b1));
		send_event(ev_touch(3'd0, 16'sd10, 16'sd10, 1'b1, 1'b0, 1'b0, 1'b1));
		send_event(ev_touch(3'd0, 16'sd10, 16'sd10, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(ev_poll());

		// Horizontal axis only: exact threshold, equal axes, vertical dominance.
		settle();
		set_config(1'b1, 1'b1, 1'b0, 8'd5);
		send_event(ev_touch(3'd2, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1));
		send_event(ev_touch(3'd2, 16'sd5, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(ev_touch(3'd2, 16'sd4, 16'sd4, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(ev_touch(3'd2, 16'sd0, 16'sd6, 1'b1, 1'b1, 1'b0, 1'b0));
		send_event(ev_touch(3'd2, -16'sd6, 16'sd1, 1'b1, 1'b1, 1'b0, 1'b1));
		send_event(ev_touch(3'd2, -16'sd6, 16'sd1, 1'b0, 1'b0, 1'b0, 1'b0));

		// Not touchable: a clean press is refused.
		settle();
		set_config(1'b0, 1'b1, 1'b0, 8'd5);
		send_event(ev_touch(3'd1, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			set_config(ph_touchable[ph], ph_drag_x[ph], ph_drag_y[ph], ph_threshold[ph]);
			if (ph < 3) begin
				send_idle_pct = 8;
				recv_idle_pct = 48;
			end else if (ph < 6) begin
				send_idle_pct = 48;
				recv_idle_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Long receiver hold-off so the pipeline fills and stalls its input.
			if (ph == 1)
				hold_req = 80;
			phase_start = sent_items;
			while (sent_items - phase_start < ph_budget[ph]) begin
				if ($urandom_range(0, 9) == 0)
					send_event(ev_noise());
				else
					run_gesture();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
